// File: rtl/core/petb_pkg.sv
`default_nettype none

package petb_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 22;
  localparam int SCALE_W  = 10;
  localparam int STEP_W   = 5;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(100);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ASSIGNED = 2'd1,
    KIND_FULL     = 2'd2
  } petb_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_SCALE = 1'b0,
    REG_TICK_STEP    = 1'b1
  } petb_reg_t;

  // Token that walks the slot chain, one cell per cycle while the chain is not stalled.
  typedef struct packed {
    logic valid;
    logic is_add;
    logic claimed;
  } petb_probe_t;

endpackage : petb_pkg

`default_nettype wire

// File: rtl/core/petb_cell.sv
`default_nettype none

module petb_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic [petb_pkg::TICK_W-1:0]    tick_count,
  input  wire logic [petb_pkg::SCALE_W-1:0]   scale,
  input  wire logic [petb_pkg::PERIOD_W-1:0]  add_period,
  input  wire petb_pkg::petb_probe_t          probe_in,
  output petb_pkg::petb_probe_t               probe_out,
  output logic                                fire,
  output logic                                claim
);
  import petb_pkg::*;

  logic                valid_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TICK_W-1:0]   last_r;
  logic [TICK_W-1:0]   limit_r;
  logic [TICK_W-1:0]   elapsed;
  petb_probe_t         probe_r;
  petb_probe_t         probe_nxt;

  always_comb begin
    elapsed = tick_count - last_r;
    fire    = probe_in.valid && !probe_in.is_add && valid_r && (elapsed > limit_r);
    claim   = probe_in.valid && probe_in.is_add && !probe_in.claimed && !valid_r;
    probe_nxt         = probe_in;
    probe_nxt.claimed = probe_in.claimed | claim;
  end

  assign probe_out = probe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r <= '0;
    end else if (advance) begin
      probe_r <= probe_nxt;
      if (claim) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Product of period and scale fits in 32 bits; hold it ready for the compare.
  always_ff @(posedge clk) begin
    limit_r <= TICK_W'(period_r) * TICK_W'(scale);
    if (advance && claim) begin
      period_r <= add_period;
      last_r   <= '0;
    end else if (advance && fire) begin
      last_r <= tick_count;
    end
  end

endmodule : petb_cell

`default_nettype wire

// File: rtl/core/periodic_event_timer_bank_unit.sv
// Periodic event timer bank.
// Input channel (in_*): one request per item. in_tuser selects the request:
//   0 = tick, 1 = add an event whose period sits in in_tdata.
// Output channel (out_*): results. out_tuser is the kind (fired, assigned,
//   full), out_tdata the slot index, out_tlast marks the final result of a
//   request. A tick in which no slot fires produces no result.
// Configuration channel (cfg_*): cfg_index 0 writes the period scale,
//   1 writes the tick step. Write only while the bank is idle.
// A request token walks a chain of NUM_SLOTS cells, one cell per cycle while
//   no result waits on a stalled receiver; the bank takes no new request
//   until the token leaves the chain end. The next request is taken while
//   the final result still waits in the output register. The final result
//   (add answer or last fire) is registered as the token leaves the chain
//   end.
// Fired results leave in ascending slot order, each one registered as the
//   token passes the next firing slot or the end of the chain.
// Reset clears the tick counter and all slot valid bits and restores the
//   scale to 100 and the step to 2.
// A result blocked by a stalled receiver holds the token and all slot state.
`default_nettype none

module periodic_event_timer_bank_unit #(
  parameter int NUM_SLOTS = petb_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: [21:0] period, [23:22] zero
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [petb_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: [0] req_type
  input  wire logic                             in_tuser,
  // out_tdata: [2:0] slot_index, [7:3] zero
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [petb_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser: [1:0] result_kind
  output logic [petb_pkg::KIND_W-1:0]           out_tuser,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [petb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [petb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import petb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W = $clog2(NUM_SLOTS + 1);

  // Configuration registers.
  logic [SCALE_W-1:0] scale_r;
  logic [STEP_W-1:0]  step_r;

  // Sequencer state.
  logic                busy_r, busy_nxt;
  logic                is_add_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  petb_probe_t         inj_r, inj_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]    claim_idx_r, claim_idx_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  petb_kind_t          out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;

  // Chain.
  petb_probe_t          probe [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] fire_vec, claim_vec;

  logic accept, advance, fire_any, claim_any, end_now;
  logic push_fire, push_end, need_push, out_free;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W+2:0]   slot_ext;

  assign cfg_ready = !busy_r;
  assign in_tready = !busy_r && !cfg_valid;
  assign accept    = in_tvalid && in_tready;

  assign probe[0] = inj_r;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    petb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .tick_count (tick_r),
      .scale      (scale_r),
      .add_period (period_r),
      .probe_in   (probe[g]),
      .probe_out  (probe[g+1]),
      .fire       (fire_vec[g]),
      .claim      (claim_vec[g])
    );
  end

  always_comb begin
    fire_any  = |fire_vec;
    claim_any = |claim_vec;
    end_now   = probe[NUM_SLOTS].valid;
    cur_idx   = IDX_W'(pos_r);
    out_free  = !out_valid_r || out_tready;
    // Flush the held fire when a newer one shows up; finish at chain end.
    push_fire = fire_any && pend_valid_r;
    push_end  = end_now && (is_add_r || pend_valid_r);
    need_push = push_fire || push_end;
    advance   = !need_push || out_free;

    busy_nxt       = busy_r;
    tick_nxt       = tick_r;
    pos_nxt        = pos_r;
    inj_nxt        = inj_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    claim_idx_nxt  = claim_idx_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      busy_nxt        = 1'b1;
      pos_nxt         = '0;
      inj_nxt.valid   = 1'b1;
      inj_nxt.is_add  = in_tuser;
      inj_nxt.claimed = 1'b0;
    end else if (busy_r && advance) begin
      inj_nxt = '0;
      pos_nxt = pos_r + POS_W'(1);
      if (fire_any) begin
        pend_valid_nxt = 1'b1;
        pend_idx_nxt   = cur_idx;
      end
      if (claim_any) begin
        claim_idx_nxt = cur_idx;
      end
      if (push_fire) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_FIRED;
        out_idx_nxt   = pend_idx_r;
        out_last_nxt  = 1'b0;
      end
      if (end_now) begin
        busy_nxt       = 1'b0;
        pend_valid_nxt = 1'b0;
        if (!is_add_r) begin
          tick_nxt = tick_r + TICK_W'(step_r);
        end
      end
      if (push_end) begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (!is_add_r) begin
          out_kind_nxt = KIND_FIRED;
          out_idx_nxt  = pend_idx_r;
        end else if (probe[NUM_SLOTS].claimed) begin
          out_kind_nxt = KIND_ASSIGNED;
          out_idx_nxt  = claim_idx_r;
        end else begin
          out_kind_nxt = KIND_FULL;
          out_idx_nxt  = '0;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_RST;
      step_r       <= STEP_RST;
      busy_r       <= 1'b0;
      tick_r       <= '0;
      pos_r        <= '0;
      inj_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      tick_r       <= tick_nxt;
      pos_r        <= pos_nxt;
      inj_r        <= inj_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (petb_reg_t'(cfg_index))
          REG_PERIOD_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
          REG_TICK_STEP:    step_r  <= cfg_data[STEP_W-1:0];
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_add_r <= in_tuser;
      period_r <= in_tdata[PERIOD_W-1:0];
    end
    pend_idx_r  <= pend_idx_nxt;
    claim_idx_r <= claim_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign slot_ext   = {3'b000, out_idx_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - SLOT_W)'(0), slot_ext[SLOT_W-1:0]};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule : periodic_event_timer_bank_unit

`default_nettype wire

// File: rtl/core/petb_checker.sv
`default_nettype none

module petb_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tready,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [petb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire logic [petb_pkg::KIND_W-1:0]      out_tuser,
  input  wire logic                             out_tlast,
  input  wire logic                             cfg_valid
);
  import petb_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed under stall");

  // Add answers are single results.
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ASSIGNED || out_tuser == KIND_FULL) |-> out_tlast)
    else $error("add answer not marked last");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FULL |-> out_tdata == '0)
    else $error("full answer carries a slot index");

  // Nothing leaves right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // No new request is taken while a config write is offered.
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !in_tready)
    else $error("request taken alongside config write");

endmodule : petb_checker

bind periodic_event_timer_bank_unit petb_checker u_petb_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import petb_pkg::*;

  localparam int NUM_SLOTS       = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Worst case for a request that leaves no result: it walks the whole chain.
  localparam int SETTLE_CYCLES   = 2 * NUM_SLOTS + 4;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef struct packed {
    petb_kind_t        kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } timer_result_t;

  // Tracks the slot table and tick counter, and queues the results each
  // accepted request must produce.
  class timer_bank_scoreboard;
    logic [SCALE_W-1:0]  period_scale;
    logic [STEP_W-1:0]   tick_step;
    logic [TICK_W-1:0]   tick_count;
    bit                  slot_valid     [NUM_SLOTS];
    logic [PERIOD_W-1:0] slot_period    [NUM_SLOTS];
    logic [TICK_W-1:0]   slot_last_fire [NUM_SLOTS];
    timer_result_t       expected_results[$];
    int errors, requests, writes, fired, assigned, full_answers;

    function new();
      period_scale = SCALE_RST;
      tick_step    = STEP_RST;
      tick_count   = '0;
      foreach (slot_valid[i]) begin
        slot_valid[i]     = 1'b0;
        slot_period[i]    = '0;
        slot_last_fire[i] = '0;
      end
    endfunction

    function void set_register(petb_reg_t index, logic [CFG_DATA_W-1:0] value);
      writes++;
      case (index)
        REG_PERIOD_SCALE: period_scale = value[SCALE_W-1:0];
        REG_TICK_STEP:    tick_step    = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic is_add, logic [PERIOD_W-1:0] period);
      timer_result_t     r;
      timer_result_t     fires[$];
      logic [TICK_W-1:0] distance;
      logic [63:0]       threshold;
      requests++;
      if (is_add) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_valid[i]) begin
            slot_valid[i]     = 1'b1;
            slot_period[i]    = period;
            slot_last_fire[i] = '0;
            r.kind = KIND_ASSIGNED;
            r.slot = SLOT_W'(i);
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
          end
        end
        r.kind = KIND_FULL;
        r.slot = '0;
        r.last = 1'b1;
        expected_results.push_back(r);
        return;
      end
      // Tick: walk valid slots in ascending order; compare the wrapped
      // distance against the full-width product.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_valid[i]) begin
          distance  = tick_count - slot_last_fire[i];
          threshold = 64'(slot_period[i]) * 64'(period_scale);
          if (64'(distance) > threshold) begin
            r.kind = KIND_FIRED;
            r.slot = SLOT_W'(i);
            r.last = 1'b0;
            fires.push_back(r);
            slot_last_fire[i] = tick_count;
          end
        end
      end
      foreach (fires[k]) begin
        r      = fires[k];
        r.last = (k == fires.size() - 1);
        expected_results.push_back(r);
      end
      tick_count = tick_count + TICK_W'(tick_step);
    endfunction

    function void check_result(petb_kind_t kind, logic [SLOT_W-1:0] slot, logic last);
      timer_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: result_kind %0d slot_index %0d last_result %0d",
               kind, slot, last);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (want.kind !== kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (want.slot !== slot) begin
        $error("slot_index: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (want.last !== last) begin
        $error("last_result: expected %0d, actual %0d", want.last, last);
        errors++;
      end
      case (want.kind)
        KIND_FIRED:    fired++;
        KIND_ASSIGNED: assigned++;
        default:       full_answers++;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  timer_bank_scoreboard sb;
  bit hold_off;   // set by the stimulus; the receiver holds off once
  bit hold_done;  // set by the receiver after its long hold
  bit calm_tail;  // no idling on either side from here on
  int cycles;

  periodic_event_timer_bank_unit #(.NUM_SLOTS(NUM_SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check every result that leaves the bank; sample the pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(petb_kind_t'(out_tuser), out_tdata[SLOT_W-1:0], out_tlast);
  end

  // Receiver: mostly ready, with random stall bursts; hold off for a long
  // stretch on demand so the bank backs up into its input.
  initial begin
    hold_done = 1'b0;
    out_tready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm_tail || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // Idle burst after a request, or none.
  function automatic int pick_gap();
    if (calm_tail || $urandom_range(0, 3) != 0)
      return 0;
    return int'($urandom_range(1, 17));
  endfunction

  // Offer one request and hold it until accepted. Keep tvalid high when the
  // next request follows at once.
  task automatic send_request(logic is_add, logic [PERIOD_W-1:0] period, int gap);
    in_tvalid <= 1'b1;
    in_tuser  <= is_add;
    in_tdata  <= IN_DATA_W'(period);
    do @(posedge clk); while (!in_tready);
    sb.note_request(is_add, period);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the input and wait until every expected result is out, then let any
  // silent tick finish its walk down the chain.
  task automatic settle_bank();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_valid high between back-to-back writes; the caller drops it.
  task automatic write_register(petb_reg_t index, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(index, value);
  endtask

  task automatic configure(logic [SCALE_W-1:0] scale, logic [STEP_W-1:0] step);
    write_register(REG_PERIOD_SCALE, CFG_DATA_W'(scale));
    write_register(REG_TICK_STEP, CFG_DATA_W'(step));
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks with some adds; once the table is full, adds answer full.
  // Ticks carry random period bits too, which the bank must ignore.
  task automatic run_random(int count);
    logic                is_add;
    logic [PERIOD_W-1:0] period;
    for (int n = 0; n < count; n++) begin
      is_add = ($urandom_range(0, 99) < 15);
      period = $urandom_range(0, 1) ? PERIOD_W'($urandom) : PERIOD_W'($urandom_range(0, 12));
      send_request(is_add, period, pick_gap());
    end
  endtask

  initial begin
    sb         = new();
    hold_off   = 1'b0;
    calm_tail  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PERIOD_SCALE;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings (scale 100, step 2).
    // Tick on an empty bank: no result, counter still advances.
    send_request(1'b0, PERIOD_MAX, pick_gap());
    // Claim slots with the period extremes and a few small ones.
    send_request(1'b1, '0, pick_gap());
    send_request(1'b1, PERIOD_MAX, pick_gap());
    send_request(1'b1, PERIOD_W'(1), pick_gap());
    // Zero-period slot fires as soon as the counter moves off its last fire.
    send_request(1'b0, '0, pick_gap());
    send_request(1'b1, PERIOD_W'(2), pick_gap());
    send_request(1'b1, PERIOD_W'(22'h2AAAAA), pick_gap());
    send_request(1'b1, PERIOD_W'(22'h155555), pick_gap());
    send_request(1'b1, PERIOD_W'(3), pick_gap());
    send_request(1'b1, PERIOD_W'(10), pick_gap());
    // Table full: answer with slot zero, once with each period extreme.
    send_request(1'b1, '0, pick_gap());
    send_request(1'b1, PERIOD_MAX, pick_gap());
    send_request(1'b0, '0, pick_gap());

    // Zero scale: every slot fires on every tick that moves the counter.
    settle_bank();
    configure(SCALE_W'(0), STEP_W'(16));
    repeat (3) send_request(1'b0, PERIOD_W'($urandom), pick_gap());

    // Zero step: the counter stands still, so nothing fires twice.
    settle_bank();
    configure(SCALE_W'(1000), STEP_W'(0));
    repeat (2) send_request(1'b0, '0, pick_gap());

    settle_bank();
    configure(SCALE_W'(1023), STEP_W'(1));
    repeat (2) send_request(1'b0, PERIOD_MAX, pick_gap());

    // Random part: small scale, unit step, so the short slots fire often.
    settle_bank();
    configure(SCALE_W'(1), STEP_W'(1));
    run_random(100);

    // Flood: all slots fire each tick while the receiver holds off, so the
    // output backs up and stalls the input.
    settle_bank();
    configure(SCALE_W'(0), STEP_W'(31));
    hold_off = 1'b1;
    repeat (40) send_request(1'b0, PERIOD_W'($urandom), 0);
    // Pause the sender until the backlog is fully drained.
    settle_bank();
    run_random(20);

    settle_bank();
    configure(SCALE_W'(1000), STEP_W'(16));
    run_random(100);

    settle_bank();
    configure(SCALE_W'(3), STEP_W'(0));
    run_random(40);

    settle_bank();
    configure(SCALE_W'($urandom_range(1, 1023)), STEP_W'($urandom_range(1, 31)));
    run_random(80);

    // Last part at full rate on both sides.
    settle_bank();
    configure(SCALE_W'(1), STEP_W'(5));
    calm_tail = 1'b1;
    run_random(100);

    settle_bank();

    $display("covered %0d requests and %0d register writes over zero, unit, large and random",
             sb.requests, sb.writes);
    $display("scale/step settings; checked %0d fires, %0d slot grants, %0d full answers",
             sb.fired, sb.assigned, sb.full_answers);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
